### rtl/core/fas_pkg.sv
// Shared types and constants of the frame animation sequencer.
// Depends on nothing; the interfaces, the sequencer unit and the checker import it.
package fas_pkg;

    // Fixed-point layout of the phase: integer frames and fraction bits.
    localparam int FRAC_BITS   = 16;
    localparam int INT_W       = 9;
    localparam int PH_W        = INT_W + FRAC_BITS;
    localparam int MAX_FRAMES  = 256;
    localparam int EVENT_SLOTS = 8;

    // Field widths.
    localparam int OP_W    = 3;
    localparam int DT_W    = 20;
    localparam int FRAME_W = 8;
    localparam int RATE_W  = 16;
    localparam int FCNT_W  = 9;
    localparam int MODE_W  = 2;
    localparam int EVC_W   = $clog2(EVENT_SLOTS + 1);

    // Product of delta_time (Q4.16) and frame_rate (Q8.8) is Q12.24.
    localparam int PROD_W = DT_W + RATE_W;
    localparam int INC_W  = PROD_W - (24 - FRAC_BITS);
    localparam int SUM_W  = INC_W + 1;
    localparam int HI_W   = SUM_W - FRAC_BITS;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd2;

    // Play modes; the unused code behaves as loop.
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_PLAY      = 3'd1,
        OP_PAUSE     = 3'd2,
        OP_STOP      = 3'd3,
        OP_SEEK      = 3'd4,
        OP_ADD_EVENT = 3'd5
    } t_op;

endpackage

### rtl/core/fas_in_if.sv
// Input channel of the frame animation sequencer: valid/ready plus item fields.
// Depends on fas_pkg.
interface fas_in_if import fas_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [DT_W-1:0]    delta_time;
    logic [FRAME_W-1:0] frame_value;

    modport source (output valid, output operation, output delta_time,
                    output frame_value, input ready);
    modport sink   (input valid, input operation, input delta_time,
                    input frame_value, output ready);
endinterface

### rtl/core/fas_out_if.sv
// Result channel of the frame animation sequencer: valid/ready plus result fields.
// Depends on fas_pkg.
interface fas_out_if import fas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FRAME_W-1:0]     current_frame;
    logic [EVENT_SLOTS-1:0] event_mask;
    logic                   frame_changed;
    logic                   is_playing;
    logic                   is_finished;
    logic [PH_W-1:0]        phase_out;

    modport source (output valid, output current_frame, output event_mask,
                    output frame_changed, output is_playing, output is_finished,
                    output phase_out, input ready);
    modport sink   (input valid, input current_frame, input event_mask,
                    input frame_changed, input is_playing, input is_finished,
                    input phase_out, output ready);
endinterface

### rtl/core/fas_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Standalone.
module fas_mul #(
    parameter int A_W = 20,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [A_W:0]     w_sum;

    // Partial sum of the high half; its LSB shifts into the low half.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[A_W:1];
            r_lo <= {w_sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

### rtl/core/fas_rem.sv
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// Standalone. Divisor must be nonzero.
module fas_rem #(
    parameter int D_W = 13,
    parameter int V_W = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [D_W-1:0] i_dividend,
    input  logic [V_W-1:0] i_divisor,
    output logic           o_done,
    output logic [V_W-1:0] o_rem
);
    localparam int CNT_W = (D_W > 1) ? $clog2(D_W) : 1;

    logic [D_W-1:0]   r_q;
    logic [V_W-1:0]   r_d;
    logic [V_W-1:0]   r_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [V_W:0]     w_trial;
    logic [V_W:0]     w_diff;
    logic             w_ge;

    assign w_trial = {r_r, r_q[D_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(D_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Without a subtract the trial is below the divisor, so it fits V_W bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[D_W-2:0], 1'b0};
            r_r <= w_ge ? w_diff[V_W-1:0] : w_trial[V_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r;
endmodule

### rtl/core/frame_animation_sequencer_unit.sv
// Frame animation sequencer: non-tick items and ignored ticks go from the input beat
// through the push state, which waits for a free output register; a running tick first
// runs the serial multiply, then the serial remainder when the phase wraps, then finish.
// One item is in flight at a time; input ready returns in the same cycle in which
// the result appears in the output register. Reset is synchronous, active low:
// phase, frame, flags and event count clear; config returns to 1 frame, 1.0 fps, loop.
module frame_animation_sequencer_unit import fas_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fas_in_if.sink                i_in,
    fas_out_if.source             o_out
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration.
    logic [FCNT_W-1:0] r_fcount;
    logic [RATE_W-1:0] r_rate;
    logic [MODE_W-1:0] r_mode;

    // Sequencer state.
    logic [PH_W-1:0]      r_phase;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_play;
    logic                 r_fin;
    logic [FRAME_W-1:0]   r_ev [EVENT_SLOTS];
    logic [EVC_W-1:0]     r_evcnt;
    logic                 r_wrap;
    logic [FRAC_BITS-1:0] r_lo;
    logic [EVENT_SLOTS-1:0] r_mask;
    logic                 r_chg;

    // Output register.
    logic                   r_ov;
    logic [FRAME_W-1:0]     r_o_frame;
    logic [EVENT_SLOTS-1:0] r_o_mask;
    logic                   r_o_chg;
    logic                   r_o_play;
    logic                   r_o_fin;
    logic [PH_W-1:0]        r_o_phase;

    logic                 w_accept;
    t_op                  w_op;
    logic                 w_run_tick;
    logic [FCNT_W-1:0]    w_n;
    logic [FCNT_W-1:0]    w_n_m1;
    logic [FCNT_W-1:0]    w_period;
    logic                 w_pp;
    logic                 w_once;
    logic                 w_mul_done;
    logic [PROD_W-1:0]    w_prod;
    logic [INC_W-1:0]     w_inc;
    logic [SUM_W-1:0]     w_sum;
    logic [HI_W-1:0]      w_sum_hi;
    logic                 w_rem_start;
    logic                 w_rem_done;
    logic [INT_W-1:0]     w_rem;
    logic [INT_W-1:0]     w_raw;
    logic [FRAME_W-1:0]   w_next;
    logic                 w_fin_chg;
    logic [EVENT_SLOTS-1:0] w_fin_mask;
    logic [FRAME_W-1:0]   w_seek;
    logic                 w_add_ok;
    logic                 w_out_free;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_op       = t_op'(i_in.operation);
    assign w_run_tick = (w_op == OP_TICK) && r_play && (i_in.delta_time != '0)
                        && (r_rate != '0);
    assign w_out_free = !r_ov || o_out.ready;

    // Effective frame count and wrap period in whole frames.
    always_comb begin
        if (r_fcount == '0) begin
            w_n = FCNT_W'(1);
        end else if (r_fcount > FCNT_W'(MAX_FRAMES)) begin
            w_n = FCNT_W'(MAX_FRAMES);
        end else begin
            w_n = r_fcount;
        end
    end
    assign w_n_m1   = w_n - 1'b1;
    assign w_pp     = (r_mode == MODE_PINGPONG);
    assign w_once   = (r_mode == MODE_ONCE);
    assign w_period = w_pp ? {w_n_m1[FCNT_W-2:0], 1'b0} : w_n;

    fas_mul #(.A_W(DT_W), .B_W(RATE_W)) u_fas_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_run_tick),
        .i_a     (i_in.delta_time),
        .i_b     (r_rate),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_inc    = w_prod[PROD_W-1 -: INC_W];
    assign w_sum    = SUM_W'(r_phase) + SUM_W'(w_inc);
    assign w_sum_hi = w_sum[SUM_W-1:FRAC_BITS];

    // The period has a zero fraction, so only the integer part is reduced.
    assign w_rem_start = (r_state == S_MUL) && w_mul_done && !w_once
                         && !(w_pp && (w_n == FCNT_W'(1)))
                         && (w_sum_hi >= HI_W'(w_period));

    fas_rem #(.D_W(HI_W), .V_W(INT_W)) u_fas_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_sum_hi),
        .i_divisor  (w_period),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // Fold the integer phase into a frame index; loop phase is already below N.
    assign w_raw = r_phase[PH_W-1:FRAC_BITS];
    always_comb begin
        if (w_n == FCNT_W'(1)) begin
            w_next = '0;
        end else if (w_pp) begin
            w_next = (w_raw < w_n) ? w_raw[FRAME_W-1:0]
                                   : FRAME_W'(w_period - w_raw);
        end else if (w_once) begin
            w_next = (w_raw >= w_n) ? w_n_m1[FRAME_W-1:0] : w_raw[FRAME_W-1:0];
        end else begin
            w_next = w_raw[FRAME_W-1:0];
        end
        w_fin_chg = (w_next != r_frame) || r_wrap;
        for (int i = 0; i < EVENT_SLOTS; i++) begin
            w_fin_mask[i] = w_fin_chg && (EVC_W'(i) < r_evcnt) && (r_ev[i] == w_next);
        end
    end

    assign w_seek   = ({1'b0, i_in.frame_value} >= w_n) ? w_n_m1[FRAME_W-1:0]
                                                         : i_in.frame_value;
    assign w_add_ok = ({1'b0, i_in.frame_value} < w_n)
                      && (r_evcnt < EVC_W'(EVENT_SLOTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = w_run_tick ? S_MUL : S_PUSH;
            S_MUL: begin
                if (w_mul_done) n_state = w_rem_start ? S_DIV : S_FIN;
            end
            S_DIV:  if (w_rem_done) n_state = S_FIN;
            S_FIN:  n_state = S_PUSH;
            S_PUSH: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcount <= FCNT_W'(1);
            r_rate   <= RATE_W'(256);
            r_mode   <= MODE_LOOP;
            r_phase  <= '0;
            r_frame  <= '0;
            r_play   <= 1'b0;
            r_fin    <= 1'b0;
            r_evcnt  <= '0;
            r_wrap   <= 1'b0;
            r_mask   <= '0;
            r_chg    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_COUNT: r_fcount <= i_cfg_data[FCNT_W-1:0];
                    CFG_FRAME_RATE:  r_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_PLAY_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_IDLE) && w_accept) begin
                r_mask <= '0;
                r_chg  <= 1'b0;
                unique case (w_op)
                    OP_TICK: ;
                    OP_PLAY: begin
                        if (r_fin && w_once) begin
                            r_phase <= '0;
                            r_frame <= '0;
                            r_fin   <= 1'b0;
                        end
                        r_play <= 1'b1;
                    end
                    OP_PAUSE: r_play <= 1'b0;
                    OP_STOP: begin
                        r_play  <= 1'b0;
                        r_phase <= '0;
                        r_frame <= '0;
                        r_fin   <= 1'b0;
                    end
                    OP_SEEK: begin
                        r_frame <= w_seek;
                        r_phase <= {1'b0, w_seek, {FRAC_BITS{1'b0}}};
                        r_fin   <= 1'b0;
                    end
                    OP_ADD_EVENT: if (w_add_ok) r_evcnt <= r_evcnt + 1'b1;
                    default: ;
                endcase
            end

            if ((r_state == S_MUL) && w_mul_done) begin
                r_wrap <= w_rem_start;
                priority if (w_once) begin
                    if (w_sum_hi >= HI_W'(w_n)) begin
                        r_phase <= {w_n, {FRAC_BITS{1'b0}}};
                        r_fin   <= 1'b1;
                        r_play  <= 1'b0;
                    end else begin
                        r_phase <= w_sum[PH_W-1:0];
                    end
                end else if (w_pp && (w_n == FCNT_W'(1))) begin
                    r_phase <= (|w_sum[SUM_W-1:PH_W]) ? {PH_W{1'b1}} : w_sum[PH_W-1:0];
                end else if (!w_rem_start) begin
                    r_phase <= w_sum[PH_W-1:0];
                end else begin
                    r_lo <= w_sum[FRAC_BITS-1:0];
                end
            end

            if ((r_state == S_DIV) && w_rem_done) begin
                r_phase <= {w_rem, r_lo};
            end

            if (r_state == S_FIN) begin
                r_frame <= w_next;
                r_mask  <= w_fin_mask;
                r_chg   <= w_fin_chg;
            end

            if ((r_state == S_PUSH) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Event slots: written in fill order, no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
            if ((r_state == S_IDLE) && w_accept && (w_op == OP_ADD_EVENT) && w_add_ok
                && (r_evcnt == EVC_W'(i))) begin
                r_ev[i] <= i_in.frame_value;
            end
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUSH) && w_out_free) begin
            r_o_frame <= r_frame;
            r_o_mask  <= r_mask;
            r_o_chg   <= r_chg;
            r_o_play  <= r_play;
            r_o_fin   <= r_fin;
            r_o_phase <= r_phase;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.current_frame = r_o_frame;
    assign o_out.event_mask    = r_o_mask;
    assign o_out.frame_changed = r_o_chg;
    assign o_out.is_playing    = r_o_play;
    assign o_out.is_finished   = r_o_fin;
    assign o_out.phase_out     = r_o_phase;
endmodule

### rtl/core/fas_checker.sv
// Port-level checks of the frame animation sequencer, bound to the top level.
// Depends on fas_pkg and frame_animation_sequencer_unit.
module fas_checker import fas_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [EVENT_SLOTS-1:0] i_out_mask,
    input logic                   i_out_changed,
    input logic [PH_W-1:0]        i_out_phase
);
    // One item at a time: no new beat right after one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

    // Events are flagged only on a frame change or wrap.
    a_mask_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_mask != '0)) |-> i_out_changed)
        else $error("event mask set without frame change");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_phase)
                                            && $stable(i_out_mask)))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind frame_animation_sequencer_unit fas_checker u_fas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_mask    (o_out.event_mask),
    .i_out_changed (o_out.frame_changed),
    .i_out_phase   (o_out.phase_out)
);
